[rtl/servo_pulse_pwm_two_channel_macros.svh]
// ----------------------------------------------------------------------------
// Servo PWM assertion macros
// Shared property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SERVO_PULSE_PWM_TWO_CHANNEL_MACROS_SVH
`define SERVO_PULSE_PWM_TWO_CHANNEL_MACROS_SVH

// same-cycle implication
`define SPP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/spp_pkg.sv]
// ----------------------------------------------------------------------------
// Servo PWM package
// Field widths, command and channel codes, register indexes, reset limits and shared types.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int US_W  = 12;
  localparam int VAL_W = 16;
  localparam int CNT_W = 16;
  localparam int IDX_W = 3;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_AUTO = 2'd1,
    CMD_US   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CH_A    = 2'd0,
    CH_B    = 2'd1,
    CH_BOTH = 2'd2
  } chan_t;

  localparam logic [IDX_W-1:0] REG_MIN_A = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_A = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_B = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_B = 3'd3;
  localparam logic [IDX_W-1:0] REG_EN_A  = 3'd4;
  localparam logic [IDX_W-1:0] REG_EN_B  = 3'd5;

  localparam logic [US_W-1:0] MIN_RESET = 12'd544;
  localparam logic [US_W-1:0] MAX_RESET = 12'd2400;

  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

  typedef struct packed {
    logic       load;
    logic [1:0] cmd;
    logic [1:0] channel;
  } upd_ctl_t;

endpackage

[rtl/spp_if.sv]
// ----------------------------------------------------------------------------
// Servo PWM channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface spp_item_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [1:0]                 channel;
  logic [spp_pkg::VAL_W-1:0]  value;

  modport source (output valid, output cmd, output channel, output value, input ready);
  modport sink   (input valid, input cmd, input channel, input value, output ready);
endinterface

interface spp_result_if;
  logic                       valid;
  logic                       ready;
  logic                       pwm_a;
  logic                       pwm_b;
  logic [spp_pkg::CNT_W-1:0]  count;

  modport source (output valid, output pwm_a, output pwm_b, output count, input ready);
  modport sink   (input valid, input pwm_a, input pwm_b, input count, output ready);
endinterface

interface spp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [spp_pkg::IDX_W-1:0]  index;
  logic [spp_pkg::US_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/spp_calc.sv]
// ----------------------------------------------------------------------------
// Servo PWM compare calculator
// Pipelined angle/microsecond to tick conversion for one channel.
// ----------------------------------------------------------------------------
module spp_calc #(
  parameter int TICKS_PER_US = 16,
  parameter int MAX_ANGLE    = 180
) (
  input  logic                      clk,
  input  spp_pkg::stage_en_t        en,
  input  logic [spp_pkg::VAL_W-1:0] value,
  input  logic [1:0]                cmd,
  input  logic [spp_pkg::US_W-1:0]  lo,
  input  logic [spp_pkg::US_W-1:0]  hi,
  output logic [spp_pkg::CNT_W-1:0] ticks
);
  import spp_pkg::*;

  localparam int AW = $clog2(MAX_ANGLE + 1);
  localparam int PW = US_W + AW;
  localparam int K  = PW + AW;
  localparam int MW = K + 1;
  localparam logic [MW-1:0] MUL =
    MW'(((64'd1 << K) + 64'(MAX_ANGLE) - 64'd1) / 64'(MAX_ANGLE));

  // stage 1 -> 2
  logic [AW-1:0]   ang1;
  logic [US_W-1:0] span1;
  logic            neg1;
  logic            below1;
  logic [PW-1:0]   mag1;

  logic [PW-1:0]    mag2;
  logic             neg2;
  logic             below2;
  logic [VAL_W-1:0] value2;

  // stage 2 -> 3
  logic [PW+MW-1:0] prod2;

  logic [US_W-1:0]  q3;
  logic             neg3;
  logic             below3;
  logic [VAL_W-1:0] value3;

  // stage 3
  logic [US_W:0]     mapped;
  logic [VAL_W-1:0]  v3;
  logic [US_W-1:0]   clamped;
  logic [US_W+4:0]   scaled;

  always_comb begin
    ang1   = (value > VAL_W'(MAX_ANGLE)) ? AW'(MAX_ANGLE) : value[AW-1:0];
    neg1   = hi < lo;
    span1  = neg1 ? (lo - hi) : (hi - lo);
    below1 = value < VAL_W'(lo);
    mag1   = PW'(span1) * PW'(ang1);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      mag2   <= mag1;
      neg2   <= neg1;
      below2 <= below1;
      value2 <= value;
    end
  end

  // exact floor(mag / MAX_ANGLE) by reciprocal
  assign prod2 = mag2 * MUL;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      q3     <= prod2[K +: US_W];
      neg3   <= neg2;
      below3 <= below2;
      value3 <= value2;
    end
  end

  always_comb begin
    if (neg3 && (q3 > lo)) begin
      mapped = '0;
    end else if (neg3) begin
      mapped = (US_W+1)'(lo) - (US_W+1)'(q3);
    end else begin
      mapped = (US_W+1)'(lo) + (US_W+1)'(q3);
    end
    v3 = (cmd == CMD_AUTO && below3) ? VAL_W'(mapped) : value3;
    if (v3 < VAL_W'(lo)) begin
      clamped = lo;
    end else if (v3 > VAL_W'(hi)) begin
      clamped = hi;
    end else begin
      clamped = v3[US_W-1:0];
    end
    scaled = (US_W+5)'(clamped) * (US_W+5)'(TICKS_PER_US);
    ticks  = scaled[CNT_W-1:0];
  end

endmodule

[rtl/spp_core.sv]
// ----------------------------------------------------------------------------
// Servo PWM timer core
// Period counter, double-buffered compares and output levels.
// ----------------------------------------------------------------------------
module spp_core (
  input  logic                      clk,
  input  logic                      rst,
  input  spp_pkg::upd_ctl_t         ctl,
  input  logic [spp_pkg::CNT_W-1:0] ticks_a,
  input  logic [spp_pkg::CNT_W-1:0] ticks_b,
  input  logic                      enable_a,
  input  logic                      enable_b,
  output logic [spp_pkg::CNT_W-1:0] count,
  output logic                      pwm_a,
  output logic                      pwm_b
);
  import spp_pkg::*;

  logic [CNT_W-1:0] counter,  counter_next;
  logic [CNT_W-1:0] act_a,    act_a_next;
  logic [CNT_W-1:0] act_b,    act_b_next;
  logic [CNT_W-1:0] pend_a,   pend_a_next;
  logic [CNT_W-1:0] pend_b,   pend_b_next;

  always_comb begin
    counter_next = counter;
    act_a_next   = act_a;
    act_b_next   = act_b;
    pend_a_next  = pend_a;
    pend_b_next  = pend_b;
    case (ctl.cmd)
      CMD_TICK: begin
        counter_next = counter + 1'b1;
        if (counter_next == '0) begin
          act_a_next = pend_a;
          act_b_next = pend_b;
        end
      end
      CMD_AUTO, CMD_US: begin
        if (ctl.channel inside {CH_A, CH_BOTH}) begin
          pend_a_next = ticks_a;
        end
        if (ctl.channel != CH_A) begin
          pend_b_next = ticks_b;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      act_a   <= '0;
      act_b   <= '0;
      pend_a  <= '0;
      pend_b  <= '0;
    end else if (ctl.load) begin
      counter <= counter_next;
      act_a   <= act_a_next;
      act_b   <= act_b_next;
      pend_a  <= pend_a_next;
      pend_b  <= pend_b_next;
    end
  end

  assign count = counter;
  assign pwm_a = enable_a && (counter <= act_a);
  assign pwm_b = enable_b && (counter <= act_b);

endmodule

[rtl/servo_pulse_pwm_two_channel.sv]
// ----------------------------------------------------------------------------
// Two-channel servo pulse generator
// Tick-driven 16-bit PWM timer with angle/microsecond compare writes.
// ----------------------------------------------------------------------------
// Usage:
//   item   : cmd (tick / write auto / write us), channel, value. A tick
//            advances the period counter; writes load a pending compare.
//   result : pwm_a, pwm_b and count after each item, one result per item.
//   cfg    : register index and data; always ready, write only when idle.
// A result is valid once its item has passed every pipeline stage below.
// Throughput: one item per cycle unless stalled; a four-stage pipeline (input
//   register, span multiply, reciprocal multiply, clamp/state update) sets it.
// Pending compares move to the active registers when the counter wraps.
// Reset: counter and all compares cleared, limits 544/2400 us, both
//   channels disabled, pipeline empty.
// Stall: when result.ready is low the result holds; earlier stages keep
//   filling bubbles and item.ready drops only once every stage is full.
// ----------------------------------------------------------------------------
`include "servo_pulse_pwm_two_channel_macros.svh"

module servo_pulse_pwm_two_channel #(
  parameter int TICKS_PER_US = 16,
  parameter int MAX_ANGLE    = 180
) (
  input  logic         clk,
  input  logic         rst,
  spp_cfg_if.sink      cfg,
  spp_item_if.sink     item,
  spp_result_if.source result
);
  import spp_pkg::*;

  logic [US_W-1:0] min_a, max_a, min_b, max_b;
  logic            enable_a, enable_b;

  logic v1, v2, v3, vo;
  logic rdy1, rdy2, rdy3, rdy_o;
  logic [1:0] cmd1, cmd2, cmd3;
  logic [1:0] ch1, ch2, ch3;
  logic [VAL_W-1:0] value1;

  stage_en_t        en;
  upd_ctl_t         ctl;
  logic [CNT_W-1:0] ticks_a, ticks_b;
  logic [CNT_W-1:0] count;
  logic             pwm_a, pwm_b;
  logic             tick_load;
  logic             pipe_full;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_a    <= MIN_RESET;
      max_a    <= MAX_RESET;
      min_b    <= MIN_RESET;
      max_b    <= MAX_RESET;
      enable_a <= 1'b0;
      enable_b <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MIN_A: min_a    <= cfg.data;
        REG_MAX_A: max_a    <= cfg.data;
        REG_MIN_B: min_b    <= cfg.data;
        REG_MAX_B: max_b    <= cfg.data;
        REG_EN_A:  enable_a <= cfg.data[0];
        REG_EN_B:  enable_b <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // per-stage advance, bubbles collapse
  assign rdy_o      = !vo || result.ready;
  assign rdy3       = !v3 || rdy_o;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign item.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy1) v1 <= item.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy_o) vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cmd1   <= item.cmd;
      ch1    <= item.channel;
      value1 <= item.value;
    end
    if (rdy2) begin
      cmd2 <= cmd1;
      ch2  <= ch1;
    end
    if (rdy3) begin
      cmd3 <= cmd2;
      ch3  <= ch2;
    end
  end

  assign en.s2       = rdy2;
  assign en.s3       = rdy3;
  assign ctl.load    = rdy_o && v3;
  assign ctl.cmd     = cmd3;
  assign ctl.channel = ch3;

  spp_calc #(
    .TICKS_PER_US(TICKS_PER_US),
    .MAX_ANGLE   (MAX_ANGLE)
  ) u_calc_a (
    .clk  (clk),
    .en   (en),
    .value(value1),
    .cmd  (cmd3),
    .lo   (min_a),
    .hi   (max_a),
    .ticks(ticks_a)
  );

  spp_calc #(
    .TICKS_PER_US(TICKS_PER_US),
    .MAX_ANGLE   (MAX_ANGLE)
  ) u_calc_b (
    .clk  (clk),
    .en   (en),
    .value(value1),
    .cmd  (cmd3),
    .lo   (min_b),
    .hi   (max_b),
    .ticks(ticks_b)
  );

  spp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .ticks_a (ticks_a),
    .ticks_b (ticks_b),
    .enable_a(enable_a),
    .enable_b(enable_b),
    .count   (count),
    .pwm_a   (pwm_a),
    .pwm_b   (pwm_b)
  );

  assign result.valid = vo;
  assign result.count = count;
  assign result.pwm_a = pwm_a;
  assign result.pwm_b = pwm_b;

  assign tick_load = ctl.load && (ctl.cmd == CMD_TICK);
  assign pipe_full = vo && v3 && v2 && v1;

  `SPP_ASSERT_NEXT(a_count_only_on_tick, !tick_load, $stable(count), "count moved without a tick")
  `SPP_ASSERT_NEXT(a_count_wrap, tick_load && count == '1, count == '0, "counter did not wrap")
  `SPP_ASSERT_SAME(a_full_blocks, pipe_full && !result.ready, !item.ready, "ready while full")

endmodule

[tb/tb_servo_pulse_pwm_two_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-channel servo pulse generator testbench
// Drives tick and compare-write items with random gaps on both sides and
// predicts every result from a local model of the counter, the pending and
// active compares and the limit registers. A checker compares each result
// in order. Covers reset defaults, angle and microsecond conversion,
// inverted limits, compare update at the counter wrap, back-pressure and
// several random register settings.
// ----------------------------------------------------------------------------
module tb_servo_pulse_pwm_two_channel;
  import spp_pkg::*;

  localparam int TICKS_PER_US = 16;
  localparam int MAX_ANGLE    = 180;
  localparam int PIPE_LAT     = 3;
  localparam int STALL_LIMIT  = 4000;
  localparam int RAND_ITEMS   = 1850;
  localparam int N_SETTINGS   = 6;

  localparam logic [1:0]       CMD_UNUSED   = 2'd3;
  localparam logic [1:0]       CH_ALIAS_B   = 2'd3;
  localparam logic [IDX_W-1:0] REG_UNDEF_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic             pwm_a;
    logic             pwm_b;
    logic [CNT_W-1:0] count;
  } pwm_sample_t;

  logic clk;
  logic rst;

  spp_item_if   item_ch ();
  spp_result_if res_ch ();
  spp_cfg_if    cfg_ch ();

  servo_pulse_pwm_two_channel uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  logic [US_W-1:0]  min_a_us, max_a_us, min_b_us, max_b_us;
  logic             en_a, en_b;
  logic [CNT_W-1:0] period_cnt;
  logic [CNT_W-1:0] cmp_a_live, cmp_b_live, cmp_a_next, cmp_b_next;
  pwm_sample_t      pending_samples[$];
  pwm_sample_t      want;

  int  items_sent, samples_seen, bad_samples, wraps_seen, reg_writes;
  int  idle_cycles;
  int  rx_hold;
  bit  rx_idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] us_to_cmp(int unsigned us, int unsigned lo,
                                                 int unsigned hi);
    int unsigned w;
    int unsigned t;
    w = us;
    if (w < lo) w = lo;
    else if (w > hi) w = hi;
    t = w * TICKS_PER_US;
    return t[CNT_W-1:0];
  endfunction

  // values under the minimum are angles, mapped onto min..max
  function automatic logic [CNT_W-1:0] auto_to_cmp(int unsigned v, int unsigned lo,
                                                   int unsigned hi);
    int unsigned w;
    int          ang, span, mapped;
    w = v;
    if (w < lo) begin
      if (w > MAX_ANGLE) w = MAX_ANGLE;
      ang    = int'(w);
      span   = int'(hi) - int'(lo);
      mapped = (ang * span) / MAX_ANGLE + int'(lo);
      if (mapped < 0) mapped = 0;
      w = 32'(mapped) & 32'h0000_FFFF;
    end
    return us_to_cmp(w, lo, hi);
  endfunction

  function automatic void predict_sample(logic [1:0] cmd, logic [1:0] chan,
                                         logic [VAL_W-1:0] val);
    pwm_sample_t s;
    if (cmd == CMD_TICK) begin
      period_cnt = period_cnt + 1'b1;
      if (period_cnt == '0) begin
        cmp_a_live = cmp_a_next;
        cmp_b_live = cmp_b_next;
        wraps_seen++;
      end
    end else if (cmd == CMD_AUTO || cmd == CMD_US) begin
      if (chan == CH_A || chan == CH_BOTH)
        cmp_a_next = (cmd == CMD_AUTO) ? auto_to_cmp(32'(val), 32'(min_a_us), 32'(max_a_us))
                                       : us_to_cmp(32'(val), 32'(min_a_us), 32'(max_a_us));
      if (chan != CH_A)
        cmp_b_next = (cmd == CMD_AUTO) ? auto_to_cmp(32'(val), 32'(min_b_us), 32'(max_b_us))
                                       : us_to_cmp(32'(val), 32'(min_b_us), 32'(max_b_us));
    end
    s.pwm_a = en_a && (period_cnt <= cmp_a_live);
    s.pwm_b = en_b && (period_cnt <= cmp_b_live);
    s.count = period_cnt;
    pending_samples.push_back(s);
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [1:0] chan, logic [VAL_W-1:0] val);
    @(negedge clk);
    item_ch.valid   <= 1'b1;
    item_ch.cmd     <= cmd;
    item_ch.channel <= chan;
    item_ch.value   <= val;
    do @(posedge clk); while (!item_ch.ready);
    predict_sample(cmd, chan, val);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 2'($urandom_range(3)), VAL_W'($urandom));
  endtask

  task automatic tx_pause(int n);
    @(negedge clk);
    item_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic int tx_gap();
    if ($urandom_range(4) != 0) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [US_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_MIN_A: min_a_us = data;
      REG_MAX_A: max_a_us = data;
      REG_MIN_B: min_b_us = data;
      REG_MAX_B: max_b_us = data;
      REG_EN_A:  en_a = data[0];
      REG_EN_B:  en_b = data[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [US_W-1:0] mna, mxa, mnb, mxb,
                               input logic ena, enb);
    logic [US_W-1:0] en_word;
    drain();
    write_reg(REG_MIN_A, mna);
    write_reg(REG_MAX_A, mxa);
    write_reg(REG_MIN_B, mnb);
    write_reg(REG_MAX_B, mxb);
    en_word    = US_W'($urandom);
    en_word[0] = ena;
    write_reg(REG_EN_A, en_word);
    en_word    = US_W'($urandom);
    en_word[0] = enb;
    write_reg(REG_EN_B, en_word);
    write_reg(($urandom_range(1) != 0) ? REG_UNDEF_HI : REG_UNDEF_LO, US_W'($urandom));
  endtask

  // limits at reset, both channels disabled
  task automatic test_reset_state();
    send_item(CMD_TICK, CH_A, '0);
    send_item(CMD_UNUSED, CH_BOTH, '1);
    send_item(CMD_AUTO, CH_A, VAL_W'(90));
    send_item(CMD_US, CH_B, VAL_W'(1500));
  endtask

  task automatic test_conversions();
    apply_setting(MIN_RESET, MAX_RESET, MIN_RESET, MAX_RESET, 1'b1, 1'b1);
    send_item(CMD_AUTO, CH_A, VAL_W'(0));
    send_item(CMD_AUTO, CH_B, VAL_W'(180));
    send_item(CMD_AUTO, CH_A, VAL_W'(181));
    send_item(CMD_AUTO, CH_B, VAL_W'(543));
    send_item(CMD_AUTO, CH_A, VAL_W'(544));
    send_item(CMD_AUTO, CH_B, VAL_W'(2400));
    send_item(CMD_AUTO, CH_A, VAL_W'(2401));
    send_item(CMD_AUTO, CH_B, '1);
    send_item(CMD_US, CH_A, '0);
    send_item(CMD_US, CH_B, '1);
    send_item(CMD_US, CH_BOTH, VAL_W'(1500));
    send_item(CMD_AUTO, CH_BOTH, VAL_W'(45));
    send_item(CMD_AUTO, CH_ALIAS_B, VAL_W'(120));
    send_item(CMD_US, CH_ALIAS_B, VAL_W'(700));
    send_item(CMD_UNUSED, CH_A, VAL_W'(1234));
    send_tick();
  endtask

  // minimum above maximum
  task automatic test_inverted_limits();
    apply_setting(12'd3000, 12'd1000, 12'd4095, 12'd0, 1'b1, 1'b1);
    send_item(CMD_AUTO, CH_A, VAL_W'(90));
    send_item(CMD_US, CH_A, VAL_W'(500));
    send_item(CMD_US, CH_A, VAL_W'(2000));
    send_item(CMD_US, CH_A, VAL_W'(4000));
    send_item(CMD_AUTO, CH_B, VAL_W'(180));
    send_item(CMD_AUTO, CH_B, VAL_W'(4094));
    send_item(CMD_US, CH_B, VAL_W'(4095));
  endtask

  // pending compares only take effect at the wrap
  task automatic test_wrap_update();
    apply_setting(MIN_RESET, MAX_RESET, MIN_RESET, MAX_RESET, 1'b1, 1'b1);
    send_item(CMD_AUTO, CH_A, VAL_W'(90));
    send_item(CMD_US, CH_B, VAL_W'(1000));
    while (period_cnt != '1) send_tick();
    send_item(CMD_US, CH_A, VAL_W'(1400));
    send_tick();
    while (period_cnt < CNT_W'(24100)) send_tick();
  endtask

  task automatic test_backpressure();
    rx_hold = 200;
    repeat (40) send_item(2'($urandom_range(2)), 2'($urandom_range(3)), VAL_W'($urandom));
  endtask

  task automatic test_random();
    logic [1:0]       cmd, chan;
    logic [VAL_W-1:0] v;
    logic [US_W-1:0]  lim;
    int               pick, g;
    for (int s = 0; s < N_SETTINGS; s++) begin
      case (s)
        0: apply_setting(MIN_RESET, MAX_RESET, MIN_RESET, MAX_RESET, 1'b1, 1'b1);
        1: apply_setting(12'd0, 12'd4095, 12'd0, 12'd4095, 1'b1, 1'b1);
        2: apply_setting(12'd4095, 12'd4095, 12'd0, 12'd0, 1'b1, 1'b1);
        3: apply_setting(12'd3000, 12'd1000, 12'd2000, 12'd100, 1'b1, 1'b0);
        4: apply_setting(US_W'($urandom), US_W'($urandom), US_W'($urandom), US_W'($urandom),
                         1'($urandom), 1'($urandom));
        default: apply_setting(12'd1000, 12'd2000, US_W'($urandom), US_W'($urandom),
                               1'b1, 1'b1);
      endcase
      rx_idle_on = (s != 2);
      for (int n = 0; n < RAND_ITEMS / N_SETTINGS; n++) begin
        pick = $urandom_range(99);
        if (pick < 45) cmd = CMD_TICK;
        else if (pick < 70) cmd = CMD_AUTO;
        else if (pick < 93) cmd = CMD_US;
        else cmd = CMD_UNUSED;
        chan = ($urandom_range(9) == 0) ? CH_ALIAS_B : 2'($urandom_range(2));
        lim  = (chan == CH_A) ? min_a_us : min_b_us;
        case ($urandom_range(5))
          0: v = VAL_W'($urandom_range(MAX_ANGLE));
          1: v = VAL_W'($urandom_range(4095));
          2: v = VAL_W'(int'(lim) + int'($urandom_range(2)) - 1);
          3: begin
            lim = (chan == CH_A) ? max_a_us : max_b_us;
            v   = VAL_W'(int'(lim) + int'($urandom_range(2)) - 1);
          end
          4: v = VAL_W'($urandom);
          default: v = ($urandom_range(1) != 0) ? '1 : VAL_W'(MAX_ANGLE + $urandom_range(1));
        endcase
        send_item(cmd, chan, v);
        g = (n < 40) ? 0 : tx_gap();
        if (g > 0) tx_pause(g);
      end
    end
    rx_idle_on = 1'b1;
  endtask

  initial begin
    int rx_gap;
    rx_gap = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        res_ch.ready <= 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        res_ch.ready <= 1'b0;
        rx_gap--;
      end else if (rx_idle_on && $urandom_range(5) == 0) begin
        res_ch.ready <= 1'b0;
        rx_gap = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(2);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      samples_seen++;
      if (pending_samples.size() == 0) begin
        bad_samples++;
        if (bad_samples <= 10)
          $display("ERROR: unexpected result pwm_a=%0b pwm_b=%0b count=%0d",
                   res_ch.pwm_a, res_ch.pwm_b, res_ch.count);
      end else begin
        want = pending_samples.pop_front();
        if (res_ch.pwm_a !== want.pwm_a || res_ch.pwm_b !== want.pwm_b ||
            res_ch.count !== want.count) begin
          bad_samples++;
          if (bad_samples <= 10)
            $display("ERROR: result %0d exp a=%0b b=%0b count=%0d got a=%0b b=%0b count=%0d",
                     samples_seen, want.pwm_a, want.pwm_b, want.count,
                     res_ch.pwm_a, res_ch.pwm_b, res_ch.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.cmd     = CMD_TICK;
    item_ch.channel = CH_A;
    item_ch.value   = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_MIN_A;
    cfg_ch.data     = '0;
    rx_idle_on      = 1'b1;
    rx_hold         = 0;
    idle_cycles     = 0;
    items_sent      = 0;
    samples_seen    = 0;
    bad_samples     = 0;
    wraps_seen      = 0;
    reg_writes      = 0;
    min_a_us        = MIN_RESET;
    max_a_us        = MAX_RESET;
    min_b_us        = MIN_RESET;
    max_b_us        = MAX_RESET;
    en_a            = 1'b0;
    en_b            = 1'b0;
    period_cnt      = '0;
    cmp_a_live      = '0;
    cmp_b_live      = '0;
    cmp_a_next      = '0;
    cmp_b_next      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_conversions();
    test_inverted_limits();
    test_wrap_update();
    test_backpressure();
    test_random();

    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);

    $display("Run: %0d items, %0d results, %0d counter wraps, %0d register writes",
             items_sent, samples_seen, wraps_seen, reg_writes);
    $display("Mismatches: %0d", bad_samples);
    if (bad_samples == 0 && pending_samples.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[servo_pulse_pwm_two_channel.f]
+incdir+rtl
rtl/spp_pkg.sv
rtl/spp_if.sv
rtl/spp_calc.sv
rtl/spp_core.sv
rtl/servo_pulse_pwm_two_channel.sv
tb/tb_servo_pulse_pwm_two_channel.sv
